// File: rtl/core/sfr_pkg.sv
// Shared types and constants for the serial-bus frame receiver.
package sfr_pkg;

  localparam int unsigned FRAME_LEN       = 25;
  localparam int unsigned STORE_LEN       = FRAME_LEN - 1;
  localparam int unsigned FLAG_IDX        = FRAME_LEN - 2;
  localparam int unsigned DATA_BYTES      = FRAME_LEN - 3;
  localparam int unsigned DATA_W          = DATA_BYTES * 8;
  localparam int unsigned NUM_CH          = 16;
  localparam int unsigned CH_W            = 11;
  localparam int unsigned CHN_W           = 4;
  localparam int unsigned POS_W           = 5;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE = 8'h00;

  // One complete frame handed from the byte collector to the channel unpacker.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              link_ok;
  } frame_job_t;

endpackage

// File: rtl/core/sfr_front.sv
// Byte collector: header search, frame capture and end-byte check.
module sfr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output sfr_pkg::frame_job_t    push_job_o
);

  localparam int unsigned IdxW = $clog2(sfr_pkg::DATA_BYTES);

  logic [sfr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                data_q [sfr_pkg::DATA_BYTES];
  logic                      flag_zero_q;
  logic                      accept;
  logic                      at_end;
  logic [sfr_pkg::POS_W-1:0] data_idx;

  assign at_end     = (pos_q >= sfr_pkg::POS_W'(sfr_pkg::STORE_LEN));
  assign in_ready_o = !at_end || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign data_idx   = pos_q - sfr_pkg::POS_W'(1);

  // Only a correct end byte at the exact end position forwards the frame.
  assign push_valid_o = in_valid_i && (pos_q == sfr_pkg::POS_W'(sfr_pkg::STORE_LEN))
                        && (rx_byte_i == sfr_pkg::END_BYTE);

  always_comb begin
    for (int i = 0; i < int'(sfr_pkg::DATA_BYTES); i++) begin
      push_job_o.data[8*i +: 8] = data_q[i];
    end
    push_job_o.link_ok = flag_zero_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_q == '0) begin
        if (rx_byte_i == sfr_pkg::HDR_BYTE) begin
          pos_d = sfr_pkg::POS_W'(1);
        end
      end else if (!at_end) begin
        pos_d = pos_q + sfr_pkg::POS_W'(1);
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q != '0 && pos_q < sfr_pkg::POS_W'(sfr_pkg::FLAG_IDX)) begin
      data_q[data_idx[IdxW-1:0]] <= rx_byte_i;
    end
    if (accept && pos_q == sfr_pkg::POS_W'(sfr_pkg::FLAG_IDX)) begin
      flag_zero_q <= (rx_byte_i == 8'h00);
    end
  end

endmodule

// File: rtl/core/sfr_queue.sv
// Small FIFO of complete frames between the collector and the unpacker.
module sfr_queue #(
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  sfr_pkg::frame_job_t push_job_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output sfr_pkg::frame_job_t pop_job_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  sfr_pkg::frame_job_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: rtl/core/sfr_back.sv
// Channel unpacker: 16 11-bit channels (one if link lost) into an output register.
module sfr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  sfr_pkg::frame_job_t           pop_job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sfr_pkg::CHN_W-1:0]     channel_number_o,
  output logic [sfr_pkg::CH_W-1:0]      channel_value_o,
  output logic                          link_ok_o,
  output logic                          last_in_frame_o
);

  logic                          busy_q;
  logic [sfr_pkg::DATA_W-1:0]    shift_q;
  logic                          ok_q;
  logic [sfr_pkg::CHN_W-1:0]     ch_q;
  logic                          out_valid_q;
  logic [sfr_pkg::CHN_W-1:0]     num_q;
  logic [sfr_pkg::CH_W-1:0]      val_q;
  logic                          ok_out_q;
  logic                          last_q;
  logic                          out_free;
  logic                          emit;
  logic                          is_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = busy_q && out_free;
  assign pop_ready_o = !busy_q;
  // A lost-link frame ends after its single result.
  assign is_last     = !ok_q || (ch_q == sfr_pkg::CHN_W'(sfr_pkg::NUM_CH - 1));

  assign out_valid_o      = out_valid_q;
  assign channel_number_o = num_q;
  assign channel_value_o  = val_q;
  assign link_ok_o        = ok_out_q;
  assign last_in_frame_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_valid_i && !busy_q) begin
        busy_q <= 1'b1;
      end else if (emit && is_last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && !busy_q) begin
      shift_q <= pop_job_i.data;
      ok_q    <= pop_job_i.link_ok;
      ch_q    <= '0;
    end else if (emit) begin
      shift_q <= shift_q >> sfr_pkg::CH_W;
      ch_q    <= ch_q + sfr_pkg::CHN_W'(1);
    end
    if (emit) begin
      num_q    <= ch_q;
      val_q    <= ok_q ? shift_q[sfr_pkg::CH_W-1:0] : '0;
      ok_out_q <= ok_q;
      last_q   <= is_last;
    end
  end

endmodule

// File: rtl/core/sbus_frame_receiver_core.sv
// Serial-bus 25-byte frame receiver: top level joining collector, queue and unpacker.
// Path with the unpacker idle: end byte, queue entry, unpacker load, output register.
// Throughput: one byte per cycle in, stalling only when the end-slot byte meets a full queue.
// The unpacker gives one result per cycle unless out_ready_i stalls it; a good frame holds it
// for load and 16 channels, a lost-link frame for load and one; the queue keeps input going.
// Reset: asynchronous active low; clears byte position, queue, unpacker busy and output valid.
module sbus_frame_receiver_core #(
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sfr_pkg::CHN_W-1:0] channel_number_o,
  output logic [sfr_pkg::CH_W-1:0]  channel_value_o,
  output logic                      link_ok_o,
  output logic                      last_in_frame_o
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  sfr_pkg::frame_job_t push_job, pop_job;

  sfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_job_o  (push_job)
  );

  sfr_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  sfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_job_i       (pop_job),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_number_o(channel_number_o),
    .channel_value_o (channel_value_o),
    .link_ok_o       (link_ok_o),
    .last_in_frame_o (last_in_frame_o)
  );

endmodule
